// ===== rtl/bst_pkg.sv =====
// Shared constants and types for the cubic B-spline tessellator.
// No dependencies; used by the top level and the divider.
`default_nettype none

package bst_pkg;

  // Defaults for the top-level parameters
  localparam int POINT_SLOTS_DEF = 16;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field and datapath widths
  localparam int STEPS_W    = 6;   // tessellation_steps
  localparam int IDX_W      = 4;   // point_index, segment_start
  localparam int SLOT_EXT_W = 9;   // slot index wide enough for 256 slots
  localparam int AW         = 22;  // signed multiplier operand A
  localparam int WW         = 21;  // basis weights and divisor 6*n^3
  localparam int SQ_W       = 12;  // n^2, i^2, (n-i)^2
  localparam int CU_W       = 18;  // n^3, i^3, (n-i)^3, i^2*n

  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(16);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_TESS  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CAP,
    ST_N2,
    ST_N3,
    ST_I2,
    ST_I3,
    ST_M2,
    ST_M3,
    ST_I2N,
    ST_W1,
    ST_W2,
    ST_MAC,
    ST_DIVGO,
    ST_DIV,
    ST_EMIT
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/cubic_bspline_tessellator_core.sv =====
// Uniform cubic B-spline tessellator. A write item (tuser = 0) stores one Q8.8 control point
// and yields nothing; a tessellate item (tuser = 1) emits n+1 curve points of the segment
// through slots c..c+3 (slots wrap around the store), n = tessellation_steps (0 acts as 1),
// the last point flagged by tlast. A tessellate item first reads the four points from the
// store and forms n^2 and n^3; per point it forms the weight products, then per coordinate
// runs the multiply-accumulate steps, launches the divider and waits for its result, and
// then emits the point, also waiting while the receiver has not taken the previous point.
// All products come from the single shared multiplier, and the bit-serial rounding divider
// divides by 6*n^3. in_tready is low for the whole run. Points read must have been written.
`default_nettype none

module cubic_bspline_tessellator_core import bst_pkg::*; #(
  parameter  int POINT_SLOTS = POINT_SLOTS_DEF,
  parameter  int COORD_BITS  = COORD_BITS_DEF,
  localparam int IN_W        = ((2 * IDX_W + 3 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W       = ((3 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration: tessellation_steps
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [STEPS_W-1:0] cfg_data,
  // input items
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_W-1:0]    in_tdata,  // point_index, point_x, point_y, point_z,
                                             // segment_start, zero pad
  input  wire logic               in_tuser,  // action
  // result items
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_W-1:0]        out_tdata, // curve_x, curve_y, curve_z, zero pad
  output logic                    out_tlast  // last_point
);

  localparam int CB     = COORD_BITS;
  localparam int PW     = AW + CB;
  localparam int ACC_W  = CB + 23;
  localparam int SLOT_W = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;

  // Reduce a small slot number modulo the store depth
  function automatic logic [SLOT_EXT_W-1:0] slot_wrap(input logic [SLOT_EXT_W-1:0] v);
    logic [SLOT_EXT_W-1:0] r;
    r = v;
    for (int s = 0; s < 4; s++) begin
      if (r >= SLOT_EXT_W'(POINT_SLOTS)) begin
        r = r - SLOT_EXT_W'(POINT_SLOTS);
      end
    end
    return r;
  endfunction

  // Saturate a rounded magnitude with its sign
  function automatic logic [CB-1:0] sat_coord(input logic neg, input logic [CB-1:0] q);
    logic [CB-1:0] lim;
    lim = {1'b1, {(CB-1){1'b0}}};
    if (neg) begin
      return (q > lim) ? lim : (~q + CB'(1));
    end
    return q[CB-1] ? ~lim : q;
  endfunction

  // Input field unpack
  logic [IDX_W-1:0]      f_index;
  logic [CB-1:0]         f_x, f_y, f_z;
  logic [IDX_W-1:0]      f_seg;
  action_t               f_action;
  logic                  in_acc;
  logic [SLOT_EXT_W-1:0] idx_ext;
  logic                  mem_we;

  assign f_index  = in_tdata[IDX_W-1:0];
  assign f_x      = in_tdata[IDX_W +: CB];
  assign f_y      = in_tdata[IDX_W + CB +: CB];
  assign f_z      = in_tdata[IDX_W + 2 * CB +: CB];
  assign f_seg    = in_tdata[IDX_W + 3 * CB +: IDX_W];
  assign f_action = action_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;
  assign idx_ext  = SLOT_EXT_W'(f_index);
  assign mem_we   = in_acc && (f_action == ACT_WRITE) &&
                    (idx_ext < SLOT_EXT_W'(POINT_SLOTS));

  // Sequencer and datapath registers
  seq_state_t           state_r, state_nxt;
  logic [STEPS_W-1:0]   steps_r;
  logic [STEPS_W-1:0]   n_r, n_nxt;
  logic [STEPS_W-1:0]   i_r, i_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [1:0]           d_r, d_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SQ_W-1:0]      n2_r, n2_nxt, i2_r, i2_nxt, m2_r, m2_nxt;
  logic [CU_W-1:0]      n3_r, n3_nxt, i3_r, i3_nxt, m3_r, m3_nxt, i2n_r, i2n_nxt;
  logic [WW-1:0]        w_r [4];
  logic [WW-1:0]        w_nxt [4];
  logic [3*CB-1:0]      cp_r [4];
  logic [3*CB-1:0]      cp_nxt [4];
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic [CB-1:0]        res_r [3];
  logic [CB-1:0]        res_nxt [3];
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [3*CB-1:0]      out_data_r, out_data_nxt;

  // Control point store
  logic [3*CB-1:0]      mem [POINT_SLOTS];
  logic [3*CB-1:0]      rd_data_r;

  // Shared multiplier and helpers
  logic signed [AW-1:0] mul_a;
  logic signed [CB-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic [STEPS_W-1:0]   m_cur;
  logic [WW-1:0]        den_w;
  logic [WW-1:0]        half_w;
  logic [WW+1:0]        w1_full;
  logic [ACC_W-1:0]     acc_mag;
  logic [ACC_W-1:0]     div_num;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [CB-1:0]        div_quo;
  logic                 emit_go;

  assign mul_p   = mul_a * mul_b;
  assign m_cur   = n_r - i_r;
  assign den_w   = WW'({n3_r, 2'b00}) + WW'({n3_r, 1'b0});
  assign half_w  = WW'({n3_r, 1'b0}) + WW'(n3_r);
  assign w1_full = (WW+2)'({i3_r, 1'b0}) + (WW+2)'(i3_r) + (WW+2)'({n3_r, 2'b00})
                 - (WW+2)'({i2n_r, 2'b00}) - (WW+2)'({i2n_r, 1'b0});
  assign acc_mag = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;
  assign div_num = acc_mag + ACC_W'(half_w);
  assign emit_go = !out_vld_r || out_tready;

  // Next state and datapath steps
  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    k_nxt        = k_r;
    d_nxt        = d_r;
    slot_nxt     = slot_r;
    n2_nxt       = n2_r;
    n3_nxt       = n3_r;
    i2_nxt       = i2_r;
    i3_nxt       = i3_r;
    m2_nxt       = m2_r;
    m3_nxt       = m3_r;
    i2n_nxt      = i2n_r;
    w_nxt        = w_r;
    cp_nxt       = cp_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    res_nxt      = res_r;
    out_last_nxt = out_last_r;
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (f_action == ACT_TESS)) begin
          n_nxt     = (steps_r == '0) ? STEPS_W'(1) : steps_r;
          i_nxt     = '0;
          k_nxt     = '0;
          slot_nxt  = SLOT_W'(slot_wrap(SLOT_EXT_W'(f_seg)));
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_CAP;
      end
      // Capture one control point, step the slot with wraparound
      ST_CAP: begin
        cp_nxt[k_r[1:0]] = rd_data_r;
        slot_nxt = (slot_r == SLOT_W'(POINT_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (k_r == 3'd3) begin
          k_nxt     = '0;
          state_nxt = ST_N2;
        end else begin
          k_nxt     = k_r + 3'd1;
          state_nxt = ST_RD;
        end
      end
      ST_N2: begin
        mul_a     = AW'(n_r);
        mul_b     = CB'(n_r);
        n2_nxt    = mul_p[SQ_W-1:0];
        state_nxt = ST_N3;
      end
      ST_N3: begin
        mul_a     = AW'(n2_r);
        mul_b     = CB'(n_r);
        n3_nxt    = mul_p[CU_W-1:0];
        state_nxt = ST_I2;
      end
      ST_I2: begin
        mul_a     = AW'(i_r);
        mul_b     = CB'(i_r);
        i2_nxt    = mul_p[SQ_W-1:0];
        state_nxt = ST_I3;
      end
      ST_I3: begin
        mul_a     = AW'(i2_r);
        mul_b     = CB'(i_r);
        i3_nxt    = mul_p[CU_W-1:0];
        state_nxt = ST_M2;
      end
      ST_M2: begin
        mul_a     = AW'(m_cur);
        mul_b     = CB'(m_cur);
        m2_nxt    = mul_p[SQ_W-1:0];
        state_nxt = ST_M3;
      end
      ST_M3: begin
        mul_a     = AW'(m2_r);
        mul_b     = CB'(m_cur);
        m3_nxt    = mul_p[CU_W-1:0];
        state_nxt = ST_I2N;
      end
      ST_I2N: begin
        mul_a     = AW'(i2_r);
        mul_b     = CB'(n_r);
        i2n_nxt   = mul_p[CU_W-1:0];
        state_nxt = ST_W1;
      end
      // Outer weights are the cubes; w1 from its polynomial
      ST_W1: begin
        w_nxt[0]  = WW'(m3_r);
        w_nxt[3]  = WW'(i3_r);
        w_nxt[1]  = w1_full[WW-1:0];
        state_nxt = ST_W2;
      end
      // Weights sum to 6*n^3
      ST_W2: begin
        w_nxt[2]  = den_w - w_r[0] - w_r[1] - w_r[3];
        k_nxt     = '0;
        d_nxt     = '0;
        state_nxt = ST_MAC;
      end
      // Multiply one weight by one coordinate, accumulate the previous product
      ST_MAC: begin
        if (k_r != 3'd4) begin
          mul_a    = AW'(w_r[k_r[1:0]]);
          mul_b    = cp_r[k_r[1:0]][d_r * CB +: CB];
          prod_nxt = mul_p;
        end
        if (k_r == 3'd1) begin
          acc_nxt = ACC_W'(prod_r);
        end else if (k_r != 3'd0) begin
          acc_nxt = acc_r + ACC_W'(prod_r);
        end
        if (k_r == 3'd4) begin
          k_nxt     = '0;
          state_nxt = ST_DIVGO;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      // Launch rounding division of |sum| + 3*n^3 by 6*n^3
      ST_DIVGO: begin
        div_start = 1'b1;
        neg_nxt   = acc_r[ACC_W-1];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_nxt[d_r] = sat_coord(neg_r, div_quo);
          if (d_r == 2'd2) begin
            state_nxt = ST_EMIT;
          end else begin
            d_nxt     = d_r + 2'd1;
            state_nxt = ST_MAC;
          end
        end
      end
      // Hand the point to the output register once it is free
      ST_EMIT: begin
        if (emit_go) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = (i_r == n_r);
          out_data_nxt = {res_r[2], res_r[1], res_r[0]};
          if (i_r == n_r) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + STEPS_W'(1);
            state_nxt = ST_I2;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      steps_r   <= STEPS_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        steps_r <= cfg_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    d_r        <= d_nxt;
    slot_r     <= slot_nxt;
    n2_r       <= n2_nxt;
    n3_r       <= n3_nxt;
    i2_r       <= i2_nxt;
    i3_r       <= i3_nxt;
    m2_r       <= m2_nxt;
    m3_r       <= m3_nxt;
    i2n_r      <= i2n_nxt;
    w_r        <= w_nxt;
    cp_r       <= cp_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Control point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_ext[SLOT_W-1:0]] <= {f_z, f_y, f_x};
    end
    rd_data_r <= mem[slot_r];
  end

  bst_div #(
    .QW   (CB),
    .NUMW (ACC_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_w),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // Divider is only launched when free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider launched while busy");

  // Divider completes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider result arrived outside the wait state");

  // A tessellate item blocks further input
  a_tess_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (f_action == ACT_TESS)) |=> !in_tready)
    else $error("input accepted during a tessellation run");

  // Step count is never zero during a run
  a_steps_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (n_r != '0))
    else $error("zero step count in a run");

endmodule

`default_nettype wire

// ===== rtl/bst_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bst_pkg for the divisor width.
`default_nettype none

module bst_div import bst_pkg::*; #(
  parameter int QW   = COORD_BITS_DEF,
  parameter int NUMW = COORD_BITS_DEF + 23
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,   // dividend, known below den * 2^QW
  input  wire logic [WW-1:0]   den,
  output logic                 busy,
  output logic                 done,
  output logic [QW-1:0]        quo
);

  localparam int CW = $clog2(QW + 1);

  logic [WW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] sh_r, sh_nxt;
  logic [WW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;

  logic [WW:0]   trial;
  logic [WW:0]   diff;
  logic          ge;

  // One shift-and-subtract step
  always_comb begin
    trial    = {rem_r, sh_r[QW-1]};
    diff     = trial - {1'b0, den_r};
    ge       = (trial >= {1'b0, den_r});
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = num[QW +: WW];
      sh_nxt  = num[QW-1:0];
      den_nxt = den;
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[WW-1:0] : trial[WW-1:0];
      sh_nxt   = {sh_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  // Hold datapath; reset only the step counter and done flag
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quo  = sh_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb_cubic_bspline_tessellator_core.sv =====
// Testbench for cubic_bspline_tessellator_core: directed table plus random items, every
// curve point checked against an in-bench B-spline evaluator or a typed row's fixed point.
// Depends on bst_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_cubic_bspline_tessellator_core import bst_pkg::*; ();

  localparam int COORD_W   = COORD_BITS_DEF;
  localparam int SLOTS     = POINT_SLOTS_DEF;
  localparam int IN_W      = ((2 * IDX_W + 3 * COORD_W + 7) / 8) * 8;
  localparam int OUT_W     = ((3 * COORD_W + 7) / 8) * 8;
  localparam int LONG_HOLD = 1500;   // receiver hold-off, in cycles
  localparam int SETTLE    = 16;     // quiet cycles before a register write
  localparam int DRAIN     = 100;    // cycles after the last curve point
  localparam int WATCHDOG  = 20000;  // cycles without any accepted item
  localparam int NUM_DIR   = 25;
  localparam int NUM_PH    = 8;

  localparam logic signed [COORD_W-1:0] CMAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last_pt;
  } curve_pt_t;

  // One stimulus row; 'typed' rows carry a fixed expected point for the whole run
  typedef struct packed {
    action_t                   act;
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [IDX_W-1:0]          seg;
    logic                      typed;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] ez;
  } stim_row_t;

  // Four equal control points give that point at every t
  localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
    '{ACT_WRITE, 4'd0,  CMAX,    CMAX,    CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd1,  CMAX,    CMAX,    CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd2,  CMAX,    CMAX,    CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd3,  CMAX,    CMAX,    CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_TESS,  4'd0,  16'sd0,  16'sd0,  16'sd0,  4'd0,  1'b1, CMAX,   CMAX,   CMAX},
    '{ACT_WRITE, 4'd0,  CMIN,    CMIN,    CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd1,  CMIN,    CMIN,    CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd2,  CMIN,    CMIN,    CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd3,  CMIN,    CMIN,    CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_TESS,  4'd0,  16'sd0,  16'sd0,  16'sd0,  4'd0,  1'b1, CMIN,   CMIN,   CMIN},
    '{ACT_WRITE, 4'd4,  CMAX,    CMIN,    16'sd0,  4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd5,  CMIN,    CMAX,    16'sd256, 4'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd6,  16'sd0,  16'sd1,  -16'sd256, 4'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd7,  16'sd1,  -16'sd1, CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd8,  -16'sd1, 16'sd0,  CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd9,  CMAX,    CMAX,    CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd10, CMIN,    CMIN,    CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd11, 16'sd1234, -16'sd4321, 16'sd77, 4'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd12, CMAX,    16'sd0,  CMIN,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd13, CMIN,    16'sd3,  CMAX,    4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd14, -16'sd5, CMAX,    16'sd640, 4'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_WRITE, 4'd15, 16'sd300, CMIN,   -16'sd2, 4'd0,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_TESS,  4'd0,  16'sd0,  16'sd0,  16'sd0,  4'd9,  1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_TESS,  4'd0,  16'sd0,  16'sd0,  16'sd0,  4'd13, 1'b0, 16'sd0, 16'sd0, 16'sd0},
    '{ACT_TESS,  4'd0,  16'sd0,  16'sd0,  16'sd0,  4'd15, 1'b0, 16'sd0, 16'sd0, 16'sd0}
  };

  // Step count per random phase (-1: small random count) and items per phase
  localparam int PH_STEPS [NUM_PH] = '{1, 63, 0, -1, 16, -1, 32, -1};
  localparam int PH_ITEMS [NUM_PH] = '{70, 6, 40, 80, 30, 80, 10, 69};

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [STEPS_W-1:0] cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;   // point_index, point_x, point_y, point_z, segment_start
  logic               in_tuser;   // action
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;  // curve_x, curve_y, curve_z
  logic               out_tlast;  // last_point

  // Bench copy of the block's state
  logic signed [COORD_W-1:0] point_store [SLOTS][3];
  logic [STEPS_W-1:0]        steps_cur;
  curve_pt_t                 expected_pts [$];

  int  err_count;
  int  quiet_cycles;
  bit  no_idle;
  bit  hold_req;

  cubic_bspline_tessellator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Coordinates lean toward the extremes and zero
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return CMAX;
    if (r == 1) return CMIN;
    if (r == 2) return '0;
    return COORD_W'($urandom());
  endfunction

  // Divide by 6n^3, round half away from zero, clamp to the coordinate range
  function automatic logic signed [COORD_W-1:0] round_sat(input longint s, input longint den);
    longint q;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -hi - 1;
    q = (s >= 0) ? (s + den / 2) / den : -((-s + den / 2) / den);
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[COORD_W-1:0];
  endfunction

  // Evaluate the segment at t = i/n for i = 0..n and queue each curve point
  function automatic void predict_segment(input logic [IDX_W-1:0] seg);
    longint    n;
    longint    n3;
    longint    m;
    longint    s;
    longint    w [4];
    curve_pt_t pt;
    logic signed [COORD_W-1:0] c [3];
    n  = (steps_cur == 0) ? 1 : longint'(steps_cur);
    n3 = n * n * n;
    for (longint i = 0; i <= n; i++) begin
      m    = n - i;
      w[0] = m * m * m;
      w[1] = 3 * i * i * i - 6 * i * i * n + 4 * n3;
      w[2] = n3 + 3 * i * n * n + 3 * i * i * n - 3 * i * i * i;
      w[3] = i * i * i;
      for (int d = 0; d < 3; d++) begin
        s = 0;
        for (int k = 0; k < 4; k++)
          s += w[k] * longint'(point_store[(int'(seg) + k) % SLOTS][d]);
        c[d] = round_sat(s, 6 * n3);
      end
      pt = '{c[0], c[1], c[2], (i == n)};
      expected_pts.insert(expected_pts.size(), pt);
    end
  endfunction

  // Update the bench state for one accepted item
  function automatic void apply_item(input stim_row_t row);
    longint    n;
    curve_pt_t pt;
    if (row.act == ACT_WRITE) begin
      point_store[row.idx][0] = row.x;
      point_store[row.idx][1] = row.y;
      point_store[row.idx][2] = row.z;
    end else if (row.typed) begin
      n = (steps_cur == 0) ? 1 : longint'(steps_cur);
      for (longint i = 0; i <= n; i++) begin
        pt = '{row.ex, row.ey, row.ez, (i == n)};
        expected_pts.insert(expected_pts.size(), pt);
      end
    end else begin
      predict_segment(row.seg);
    end
  endfunction

  // Offer one item after a random gap; return at the edge that accepts it
  task automatic drive_item(input stim_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.act;
    in_tdata  <= IN_W'({row.seg, row.z, row.y, row.x, row.idx});
    do @(posedge clk); while (!in_tready);
    apply_item(row);
  endtask

  // Hold the input until every queued curve point has come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pts.size() > 0) @(posedge clk);
  endtask

  task automatic set_steps(input logic [STEPS_W-1:0] v);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    steps_cur = v;
  endtask

  // Stimulus
  initial begin
    stim_row_t row;
    int        v;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= ACT_WRITE;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    steps_cur  = STEPS_RESET;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at the reset step count
    for (int r = 0; r < NUM_DIR; r++)
      drive_item(DIR_ROWS[r]);

    // Random phases, each at its own step count
    for (int p = 0; p < NUM_PH; p++) begin
      wait_idle();
      v = (PH_STEPS[p] < 0) ? $urandom_range(10, 2) : PH_STEPS[p];
      set_steps(STEPS_W'(v));
      no_idle = (p % 3 == 1);
      if (p == 4) hold_req = 1'b1;
      for (int k = 0; k < PH_ITEMS[p]; k++) begin
        if (p == 3 && k == PH_ITEMS[p] / 2) wait_idle();
        row.act   = ($urandom_range(99, 0) < 45 || (p == 4 && k < 2)) ? ACT_TESS : ACT_WRITE;
        row.idx   = IDX_W'($urandom_range(SLOTS - 1, 0));
        row.x     = rand_coord();
        row.y     = rand_coord();
        row.z     = rand_coord();
        row.seg   = IDX_W'($urandom_range(SLOTS - 1, 0));
        row.typed = 1'b0;
        row.ex    = '0;
        row.ey    = '0;
        row.ez    = '0;
        drive_item(row);
      end
    end

    // Drain and report
    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (err_count == 0 && expected_pts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int rx_gap;
    bit held;
    rx_gap = 0;
    held   = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap--;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        rx_gap = pick_gap();
        @(posedge clk);
      end
    end
  end

  // Compare each accepted curve point with the oldest expectation
  always @(posedge clk) begin
    curve_pt_t got;
    curve_pt_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[COORD_W-1:0], out_tdata[2*COORD_W-1:COORD_W],
              out_tdata[3*COORD_W-1:2*COORD_W], out_tlast};
      if (expected_pts.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected curve point x=%0d y=%0d z=%0d last=%0d",
                   got.x, got.y, got.z, got.last_pt);
      end else begin
        want = expected_pts.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.last_pt !== want.last_pt) begin
          err_count++;
          if (err_count <= 10)
            $display("curve point mismatch: expected x=%0d y=%0d z=%0d last=%0d, ",
                     want.x, want.y, want.z, want.last_pt,
                     "got x=%0d y=%0d z=%0d last=%0d",
                     got.x, got.y, got.z, got.last_pt);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
